// File: hdl/assert_macros.svh
// Assertion macros shared by the keypad passcode entry RTL.
// Each macro expects signals named clk and rst in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hdl/kpe_pkg.sv
// Package for the keypad passcode entry block: request and response types
// and the fixed cell and verdict codes. It depends on nothing else.
package kpe_pkg;

  localparam int PASS_W = 16;
  localparam int CELL_W = 4;

  localparam logic [CELL_W-1:0] CODE_BLANK   = 4'd10;
  localparam logic [CELL_W-1:0] CODE_ERROR   = 4'd11;
  localparam logic [CELL_W-1:0] CODE_SUCCESS = 4'd12;
  localparam logic [CELL_W-1:0] DIGIT_MAX    = 4'd9;
  localparam logic [CELL_W-1:0] DIGIT_ZERO   = 4'd0;

  localparam logic [PASS_W-1:0] PASS_RESET = 16'h9583;

  localparam logic [1:0] VERDICT_NONE  = 2'd0;
  localparam logic [1:0] VERDICT_MATCH = 2'd1;
  localparam logic [1:0] VERDICT_WRONG = 2'd2;

  typedef struct packed {
    logic btn_next;
    logic btn_prev;
    logic btn_inc;
    logic btn_clear;
    logic mode_switch;
  } kpe_req_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell0;
    logic [CELL_W-1:0] cell1;
    logic [CELL_W-1:0] cell2;
    logic [CELL_W-1:0] cell3;
    logic [1:0]        cursor_pos;
    logic [1:0]        verdict;
    logic              mode_now;
  } kpe_res_t;

endpackage

// File: hdl/kpe_match.sv
// Compares the digit cells with the configured passcode, first cell against
// the top nibble. Depends on kpe_pkg for the cell and code widths.
module kpe_match #(
  parameter int NUM_CELLS = 4
) (
  input  logic [NUM_CELLS-1:0][kpe_pkg::CELL_W-1:0] cells,
  input  logic [kpe_pkg::PASS_W-1:0]                pass_code,
  output logic                                      match
);
  import kpe_pkg::*;

  logic [NUM_CELLS-1:0] eq;

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    localparam int SH = CELL_W * (NUM_CELLS - 1 - i);
    if (SH < PASS_W) begin : g_coded
      assign eq[i] = (cells[i] == pass_code[SH +: CELL_W]);
    end else begin : g_zero
      assign eq[i] = (cells[i] == DIGIT_ZERO);
    end
  end

  assign match = &eq;

endmodule

// File: hdl/kpe_step.sv
// Next-state logic for one button sample: lock, increment, clear, shift or
// cursor move, then the passcode check. Depends on kpe_pkg and kpe_match.
module kpe_step #(
  parameter int NUM_CELLS = 4,
  parameter int CW        = 3
) (
  input  kpe_pkg::kpe_req_t                         req,
  input  logic [NUM_CELLS-1:0][kpe_pkg::CELL_W-1:0] cells,
  input  logic [CW-1:0]                             cursor,
  input  logic [CW-1:0]                             count,
  input  logic                                      armed,
  input  logic                                      mode,
  input  logic [kpe_pkg::PASS_W-1:0]                pass_code,
  output logic [NUM_CELLS-1:0][kpe_pkg::CELL_W-1:0] cells_next,
  output logic [CW-1:0]                             cursor_next,
  output logic [CW-1:0]                             count_next,
  output logic                                      armed_next,
  output logic                                      mode_next,
  output kpe_pkg::kpe_res_t                         res
);
  import kpe_pkg::*;

  logic [NUM_CELLS-1:0][CELL_W-1:0] cells_mid;
  logic [CW-1:0]                    cursor_mid;
  logic [CW-1:0]                    count_mid;
  logic                             match;
  logic                             check;
  logic [3:0][CELL_W-1:0]           disp;
  logic [1:0]                       verdict;

  always_comb begin
    cells_mid  = cells;
    cursor_mid = cursor;
    count_mid  = count;
    armed_next = armed;
    if (req.btn_inc && armed_next) begin
      for (int i = 0; i < NUM_CELLS; i++) begin
        if (cursor_mid == CW'(i)) begin
          cells_mid[i] = (cells_mid[i] >= DIGIT_MAX) ? DIGIT_ZERO
                                                     : cells_mid[i] + CELL_W'(1);
        end
      end
      armed_next = 1'b0;
    end
    if (req.btn_clear && armed_next) begin
      for (int i = 0; i < NUM_CELLS; i++) begin
        cells_mid[i] = CODE_BLANK;
      end
      cursor_mid = '0;
      count_mid  = '0;
      armed_next = 1'b0;
    end
    if (!req.btn_next && !req.btn_prev && !req.btn_inc && !req.btn_clear && !armed_next) begin
      armed_next = 1'b1;
    end
    if (!mode) begin
      if (req.btn_next && armed_next) begin
        if (count_mid < CW'(NUM_CELLS - 1)) begin
          for (int i = NUM_CELLS - 1; i >= 1; i--) begin
            cells_mid[i] = cells_mid[i-1];
          end
        end
        if (count_mid < CW'(NUM_CELLS)) begin
          count_mid = count_mid + CW'(1);
        end
        armed_next = 1'b0;
      end
    end else begin
      if (req.btn_next && armed_next) begin
        cursor_mid = (cursor_mid > CW'(NUM_CELLS - 1)) ? '0 : cursor_mid + CW'(1);
        armed_next = 1'b0;
      end
      if (req.btn_prev && armed_next) begin
        cursor_mid = (cursor_mid == '0) ? CW'(NUM_CELLS - 1) : cursor_mid - CW'(1);
        armed_next = 1'b0;
      end
    end
  end

  kpe_match #(
    .NUM_CELLS(NUM_CELLS)
  ) u_match (
    .cells    (cells_mid),
    .pass_code(pass_code),
    .match    (match)
  );

  assign check = (cursor_mid == CW'(NUM_CELLS)) || (count_mid == CW'(NUM_CELLS));

  always_comb begin
    cells_next  = cells_mid;
    cursor_next = cursor_mid;
    count_next  = count_mid;
    verdict     = VERDICT_NONE;
    if (check) begin
      for (int i = 0; i < NUM_CELLS; i++) begin
        cells_next[i] = match ? CODE_SUCCESS : CODE_ERROR;
      end
      verdict = match ? VERDICT_MATCH : VERDICT_WRONG;
      if (mode) begin
        cursor_next = '0;
      end else begin
        count_next = '0;
      end
    end
    mode_next = req.mode_switch;
    if (!mode_next) begin
      cursor_next = '0;
    end
  end

  for (genvar i = 0; i < 4; i++) begin : g_disp
    if (i < NUM_CELLS) begin : g_real
      assign disp[i] = cells_next[i];
    end else begin : g_pad
      assign disp[i] = CODE_BLANK;
    end
  end

  assign res.cell0      = disp[0];
  assign res.cell1      = disp[1];
  assign res.cell2      = disp[2];
  assign res.cell3      = disp[3];
  assign res.cursor_pos = cursor_next[1:0];
  assign res.verdict    = verdict;
  assign res.mode_now   = mode_next;

endmodule

// File: hdl/keypad_passcode_entry.sv
// Keypad passcode entry: a request is accepted into an input register and its
// response is registered in the result register when that register can take
// it. One request is taken every cycle while rsp_ready keeps the output moving,
// the result register and input register both advancing.
// Synchronous reset blanks the cells, clears cursor, count and mode, arms the
// lock and loads the passcode with 9583 hex.
module keypad_passcode_entry #(
  parameter int NUM_CELLS = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [kpe_pkg::PASS_W-1:0]   cfg_wdata,
  input  logic                         req_valid,
  output logic                         req_ready,
  input  kpe_pkg::kpe_req_t            req_data,
  output logic                         rsp_valid,
  input  logic                         rsp_ready,
  output kpe_pkg::kpe_res_t            rsp_data
);
  import kpe_pkg::*;
  `include "assert_macros.svh"

  localparam int CW = $clog2(NUM_CELLS + 1);

  logic [PASS_W-1:0]                pass_code;
  logic                             stage_valid;
  kpe_req_t                         stage_req;
  logic                             stage_fire;
  logic [NUM_CELLS-1:0][CELL_W-1:0] cells;
  logic [CW-1:0]                    cursor;
  logic [CW-1:0]                    count;
  logic                             armed;
  logic                             mode;
  logic [NUM_CELLS-1:0][CELL_W-1:0] cells_next;
  logic [CW-1:0]                    cursor_next;
  logic [CW-1:0]                    count_next;
  logic                             armed_next;
  logic                             mode_next;
  kpe_res_t                         res_next;

  assign stage_fire = stage_valid && (!rsp_valid || rsp_ready);
  assign req_ready  = !stage_valid || stage_fire;

  kpe_step #(
    .NUM_CELLS(NUM_CELLS),
    .CW       (CW)
  ) u_step (
    .req        (stage_req),
    .cells      (cells),
    .cursor     (cursor),
    .count      (count),
    .armed      (armed),
    .mode       (mode),
    .pass_code  (pass_code),
    .cells_next (cells_next),
    .cursor_next(cursor_next),
    .count_next (count_next),
    .armed_next (armed_next),
    .mode_next  (mode_next),
    .res        (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pass_code <= PASS_RESET;
    end else if (cfg_we) begin
      pass_code <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (req_ready) begin
      stage_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      stage_req <= req_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CELLS; i++) begin
        cells[i] <= CODE_BLANK;
      end
      cursor    <= '0;
      count     <= '0;
      armed     <= 1'b1;
      mode      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (stage_fire) begin
        cells     <= cells_next;
        cursor    <= cursor_next;
        count     <= count_next;
        armed     <= armed_next;
        mode      <= mode_next;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage_fire) begin
      rsp_data <= res_next;
    end
  end

  `ASSERT_IMPLIES(a_cursor_range, 1'b1, cursor < CW'(NUM_CELLS))
  `ASSERT_IMPLIES(a_count_range, 1'b1, count < CW'(NUM_CELLS))
  `ASSERT_IMPLIES(a_simple_cursor, !mode, cursor == '0)
  `ASSERT_NEXT(a_fire_gives_rsp, stage_fire, rsp_valid && (rsp_data.mode_now == mode))

endmodule
